### hdl/dcws_pkg.sv
// shared types, constants and helpers of the dial count to wheel scaler
package dcws_pkg;

  localparam int NUM_SENSORS = 4;
  localparam int NUM_LAYERS  = 16;
  localparam int SLOTS       = NUM_SENSORS * NUM_LAYERS;
  localparam int SLOT_AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int COUNT_W = 32;
  localparam int SCALE_W = 16;
  localparam int REM_W   = SCALE_W + 1;
  localparam int TOTAL_W = COUNT_W + SCALE_W + 1;
  localparam int MAG_W   = TOTAL_W - 1;
  localparam int DIV_CW  = $clog2(MAG_W + 1);
  localparam int CODE_W  = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_CODE    = CFG_IDX_W'(1);

  localparam logic KIND_ACCEPT  = 1'b0;
  localparam logic KIND_PROCESS = 1'b1;

  localparam logic [1:0] ST_ACCEPTED    = 2'd0;
  localparam logic [1:0] ST_TRANSPARENT = 2'd1;
  localparam logic [1:0] ST_OPAQUE      = 2'd2;
  localparam logic [1:0] ST_INVALID     = 2'd3;

  typedef struct packed {
    logic                      kind;
    logic [1:0]                sensor_index;
    logic [3:0]                layer_index;
    logic signed [COUNT_W-1:0] counts;
    logic                      trigger;
    logic [SCALE_W-1:0]        scale_numerator;
    logic [SCALE_W-1:0]        scale_denominator;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      report_valid;
    logic signed [COUNT_W-1:0] wheel_step;
    logic [CODE_W-1:0]         report_code;
  } out_item_t;

  typedef struct packed {
    logic                    done;
    logic                    quo_neg;
    logic [MAG_W-1:0]        quo_mag;
    logic signed [REM_W-1:0] rem;
  } div_res_t;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [1:0] sensor,
                                                   input logic [3:0] layer);
    int a;
    a = int'(sensor) * NUM_LAYERS + int'(layer);
    return a[SLOT_AW-1:0];
  endfunction

  function automatic logic slot_in_range(input logic [1:0] sensor,
                                         input logic [3:0] layer);
    return (int'(sensor) < NUM_SENSORS) && (int'(layer) < NUM_LAYERS);
  endfunction

endpackage

### hdl/dial_count_to_wheel_scaler_top.sv
// top level of the dial count to wheel scaler
//
//  channel | signals                                  | transaction when
//  --------+------------------------------------------+----------------------------
//  input   | in_valid, in_stall, in_item              | in_valid & !in_stall
//  output  | out_valid, out_stall, out_item           | out_valid & !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//
//  one item at a time; only a scaled process item also passes through
//  the 48-step serial divider
//  rst is synchronous; both slot stores read as zero after reset through
//  per-slot valid bits, so no clearing pass is needed
//  a finished result waits in the output register under out_stall while the
//  next item may already be taken
module dial_count_to_wheel_scaler_top import dcws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]                state;
  logic                      scroll_enable;
  logic [CODE_W-1:0]         event_code;
  in_item_t                  item;
  logic [SLOT_AW-1:0]        addr;
  logic                      in_range;
  logic [SLOTS-1:0]          pend_vld;
  logic [SLOTS-1:0]          rem_vld;
  logic signed [COUNT_W-1:0] cnt_r;
  logic signed [REM_W-1:0]   rem_r;
  logic signed [TOTAL_W-1:0] prod;
  logic signed [TOTAL_W-1:0] total;
  out_item_t                 res;

  logic                      accept;
  logic [SLOT_AW-1:0]        in_addr;
  logic                      pend_we;
  logic [COUNT_W-1:0]        pend_wdata;
  logic [COUNT_W-1:0]        pend_rdata;
  logic                      rem_we;
  logic [REM_W-1:0]          rem_rdata;
  logic signed [COUNT_W-1:0] cnt;
  logic signed [REM_W-1:0]   rem;
  logic                      div_start;
  div_res_t                  div_res;
  logic signed [COUNT_W-1:0] step;
  logic                      step_nz;
  logic                      out_free;
  logic [1:0]                status_next;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_addr   = slot_addr(in_item.sensor_index, in_item.layer_index);
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_DSTART);

  assign cnt = (in_range && pend_vld[addr]) ? $signed(pend_rdata) : '0;
  assign rem = rem_vld[addr] ? $signed(rem_rdata) : '0;

  assign pend_we    = (state == S_READ) && in_range;
  assign pend_wdata = (item.kind == KIND_ACCEPT) ? item.counts : '0;
  assign rem_we     = (state == S_DIV) && div_res.done;

  dcws_ram #(.WIDTH(COUNT_W), .DEPTH(SLOTS)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (addr),
    .wdata (pend_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (pend_rdata)
  );

  dcws_ram #(.WIDTH(REM_W), .DEPTH(SLOTS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (addr),
    .wdata (div_res.rem),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rem_rdata)
  );

  dcws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (item.scale_denominator),
    .res      (div_res)
  );

  always_comb begin
    if (item.kind == KIND_ACCEPT) begin
      status_next = ST_ACCEPTED;
    end else if (!item.trigger || cnt == '0) begin
      status_next = ST_TRANSPARENT;
    end else if (!scroll_enable) begin
      status_next = ST_OPAQUE;
    end else if (item.scale_numerator == '0 || item.scale_denominator == '0) begin
      status_next = ST_INVALID;
    end else begin
      status_next = ST_OPAQUE;
    end
  end

  // saturate the quotient to the 32-bit signed range
  always_comb begin
    step_nz = |div_res.quo_mag;
    if (!div_res.quo_neg) begin
      if (|div_res.quo_mag[MAG_W-1:COUNT_W-1]) begin
        step = {1'b0, {(COUNT_W-1){1'b1}}};
      end else begin
        step = $signed(div_res.quo_mag[COUNT_W-1:0]);
      end
    end else begin
      if ((|div_res.quo_mag[MAG_W-1:COUNT_W]) ||
          (div_res.quo_mag[COUNT_W-1] && (|div_res.quo_mag[COUNT_W-2:0]))) begin
        step = {1'b1, {(COUNT_W-1){1'b0}}};
      end else begin
        step = -$signed(div_res.quo_mag[COUNT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_enable <= 1'b1;
      event_code    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCROLL_ENABLE: scroll_enable <= cfg_data[0];
        CFG_EVENT_CODE:    event_code    <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_vld  <= '0;
      rem_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pend_we) begin
        pend_vld[addr] <= 1'b1;
      end
      if (rem_we) begin
        rem_vld[addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (item.kind == KIND_ACCEPT) begin
            state <= S_OUT;
          end else if (!item.trigger || cnt == '0) begin
            state <= S_OUT;
          end else if (!scroll_enable) begin
            state <= S_OUT;
          end else if (item.scale_numerator == '0 || item.scale_denominator == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL:    state <= S_ADD;
        S_ADD:    state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_res.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= in_item;
      addr     <= in_addr;
      in_range <= slot_in_range(in_item.sensor_index, in_item.layer_index);
    end
    if (state == S_READ) begin
      cnt_r <= cnt;
      rem_r <= rem;
      res   <= {status_next, {($bits(out_item_t) - 2){1'b0}}};
    end
    if (state == S_MUL) begin
      prod <= TOTAL_W'(cnt_r) * TOTAL_W'($signed({1'b0, item.scale_numerator}));
    end
    if (state == S_ADD) begin
      total <= prod + TOTAL_W'(rem_r);
    end
    if (rem_we) begin
      res.report_valid <= step_nz;
      res.wheel_step   <= step_nz ? step : '0;
      res.report_code  <= step_nz ? event_code : '0;
    end
    if (state == S_OUT && out_free) begin
      out_item <= res;
    end
  end

endmodule

### hdl/dcws_ram.sv
// generic single-port-write ram with registered read
module dcws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/dcws_div.sv
// bit-serial signed-by-unsigned divider, truncating toward zero
module dcws_div import dcws_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [TOTAL_W-1:0] dividend,
  input  logic [SCALE_W-1:0]        divisor,
  output div_res_t                  res
);

  logic                busy;
  logic                done;
  logic                neg;
  logic [MAG_W-1:0]    mag;
  logic [SCALE_W-1:0]  racc;
  logic [SCALE_W-1:0]  dvs;
  logic [DIV_CW-1:0]   cnt;
  logic [SCALE_W:0]    trial;
  logic [SCALE_W:0]    diff;
  logic                qbit;
  logic [TOTAL_W-1:0]  neg_total;

  assign trial     = {racc, mag[MAG_W-1]};
  assign diff      = trial - {1'b0, dvs};
  assign qbit      = trial >= {1'b0, dvs};
  assign neg_total = ~dividend + TOTAL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[TOTAL_W-1];
      mag  <= dividend[TOTAL_W-1] ? neg_total[MAG_W-1:0] : dividend[MAG_W-1:0];
      racc <= '0;
      dvs  <= divisor;
      cnt  <= DIV_CW'(MAG_W);
    end else if (busy) begin
      mag  <= {mag[MAG_W-2:0], qbit};
      racc <= qbit ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
      cnt  <= cnt - DIV_CW'(1);
    end
  end

  always_comb begin
    res.done    = done;
    res.quo_neg = neg;
    res.quo_mag = mag;
    res.rem     = neg ? -$signed({1'b0, racc}) : $signed({1'b0, racc});
  end

endmodule

### tb/sv/dial_count_to_wheel_scaler_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the dial count to wheel scaler top level
module dial_count_to_wheel_scaler_top_test;
  import dcws_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dial_count_to_wheel_scaler_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [COUNT_W-1:0] pend_cnt [NUM_SENSORS][NUM_LAYERS];
  longint                    rem_store [NUM_SENSORS][NUM_LAYERS];
  logic                      scroll_en;
  logic [CODE_W-1:0]         evt_code;

  out_item_t wheel_q [$];
  out_item_t exp_item;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        idle_pct = 35;
  int        stall_pct = 35;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic out_item_t predict_wheel(input in_item_t it);
    out_item_t          r;
    logic signed [31:0] cnt;
    longint             total;
    longint             q;
    longint             num;
    longint             den;
    r = '0;
    num = {48'd0, it.scale_numerator};
    den = {48'd0, it.scale_denominator};
    if (it.kind == KIND_ACCEPT) begin
      pend_cnt[it.sensor_index][it.layer_index] = it.counts;
      r.status = ST_ACCEPTED;
    end else begin
      cnt = pend_cnt[it.sensor_index][it.layer_index];
      pend_cnt[it.sensor_index][it.layer_index] = '0;
      if (!it.trigger || cnt == 0) begin
        r.status = ST_TRANSPARENT;
      end else if (!scroll_en) begin
        r.status = ST_OPAQUE;
      end else if (num == 0 || den == 0) begin
        r.status = ST_INVALID;
      end else begin
        total = rem_store[it.sensor_index][it.layer_index] + longint'(cnt) * num;
        q = total / den;
        rem_store[it.sensor_index][it.layer_index] = total - q * den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        if (q != 0) begin
          r.report_valid = 1'b1;
          r.wheel_step = q[31:0];
          r.report_code = evt_code;
        end
        r.status = ST_OPAQUE;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (wheel_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        exp_item = wheel_q.pop_front();
        check_field("status", exp_item.status, out_item.status);
        check_field("report_valid", exp_item.report_valid, out_item.report_valid);
        check_field("wheel_step", exp_item.wheel_step, out_item.wheel_step);
        check_field("report_code", exp_item.report_code, out_item.report_code);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    wheel_q.push_back(predict_wheel(it));
  endtask

  task automatic accept_counts(input int s, input int l, input logic [31:0] cnt);
    in_item_t it;
    it.kind = KIND_ACCEPT;
    it.sensor_index = s[1:0];
    it.layer_index = l[3:0];
    it.counts = cnt;
    it.trigger = 1'($urandom_range(1));
    it.scale_numerator = 16'($urandom);
    it.scale_denominator = 16'($urandom);
    send_item(it);
  endtask

  task automatic process_slot(input int s, input int l, input logic trig,
                              input logic [15:0] num, input logic [15:0] den);
    in_item_t it;
    it.kind = KIND_PROCESS;
    it.sensor_index = s[1:0];
    it.layer_index = l[3:0];
    it.counts = $urandom;
    it.trigger = trig;
    it.scale_numerator = num;
    it.scale_denominator = den;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SCROLL_ENABLE) scroll_en = val[0];
    else if (idx == CFG_EVENT_CODE) evt_code = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_counts();
    case ($urandom_range(4))
      0: return $urandom_range(2000) - 1000;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      3: return $urandom_range(20) - 10;
      default: return $urandom_range(200000) - 100000;
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'hffff;
      2, 3, 4: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_defaults();
    process_slot(0, 0, 1'b1, 16'd1, 16'd1);
    accept_counts(0, 0, 32'd3);
    process_slot(0, 0, 1'b1, 16'd1, 16'd1);
  endtask

  task automatic test_special_cases();
    // non-trigger clears the pending count
    accept_counts(1, 2, 32'd5);
    process_slot(1, 2, 1'b0, 16'd1, 16'd1);
    process_slot(1, 2, 1'b1, 16'd1, 16'd1);
    // zero numerator, zero denominator
    accept_counts(1, 2, 32'd7);
    process_slot(1, 2, 1'b1, 16'd0, 16'd5);
    accept_counts(1, 2, 32'd7);
    process_slot(1, 2, 1'b1, 16'd5, 16'd0);
    // zero step keeps the remainder
    accept_counts(2, 3, 32'd1);
    process_slot(2, 3, 1'b1, 16'd1, 16'd3);
    accept_counts(2, 3, 32'd2);
    process_slot(2, 3, 1'b1, 16'd1, 16'd3);
    // negative remainder
    accept_counts(2, 4, -32'sd1);
    process_slot(2, 4, 1'b1, 16'd1, 16'hffff);
    accept_counts(2, 4, -32'sd65534);
    process_slot(2, 4, 1'b1, 16'd1, 16'hffff);
  endtask

  task automatic test_extremes();
    accept_counts(3, 15, 32'h7fffffff);
    process_slot(3, 15, 1'b1, 16'hffff, 16'd1);
    accept_counts(3, 15, 32'h80000000);
    process_slot(3, 15, 1'b1, 16'hffff, 16'd1);
    accept_counts(3, 14, 32'h7fffffff);
    process_slot(3, 14, 1'b1, 16'hffff, 16'hffff);
  endtask

  task automatic test_config_registers();
    write_reg(CFG_EVENT_CODE, 16'hffff);
    accept_counts(0, 1, 32'd100);
    process_slot(0, 1, 1'b1, 16'd3, 16'd7);
    write_reg(CFG_SCROLL_ENABLE, 16'd0);
    accept_counts(0, 1, 32'd100);
    process_slot(0, 1, 1'b1, 16'd3, 16'd7);
    write_reg(CFG_SCROLL_ENABLE, 16'd1);
  endtask

  task automatic run_random(input int n);
    int             sent;
    int             s;
    int             l;
    logic [95:0]    raw;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 75) begin
        // hot slots exercise remainder carry
        if ($urandom_range(1)) begin
          s = $urandom_range(1);
          l = $urandom_range(1);
        end else begin
          s = $urandom_range(NUM_SENSORS - 1);
          l = $urandom_range(NUM_LAYERS - 1);
        end
        accept_counts(s, l, rand_counts());
        process_slot(s, l, $urandom_range(9) != 0, rand_scale(), rand_scale());
        sent += 2;
      end else begin
        raw = {$urandom, $urandom, $urandom};
        send_item(raw[$bits(in_item_t)-1:0]);
        sent += 1;
      end
    end
  endtask

  task automatic test_random_traffic();
    write_reg(CFG_EVENT_CODE, 16'd0);
    run_random(200);
    write_reg(CFG_EVENT_CODE, 16'hffff);
    run_random(200);
    write_reg(CFG_EVENT_CODE, 16'($urandom));
    run_random(200);
    write_reg(CFG_SCROLL_ENABLE, 16'd0);
    run_random(60);
    write_reg(CFG_SCROLL_ENABLE, 16'd1);
    write_reg(CFG_EVENT_CODE, 16'd1);
    // back to back traffic with no idling
    idle_pct = 0;
    stall_pct = 0;
    run_random(200);
    idle_pct = 35;
    stall_pct = 35;
  endtask

  initial begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      for (int l = 0; l < NUM_LAYERS; l++) begin
        pend_cnt[s][l] = '0;
        rem_store[s][l] = 0;
      end
    end
    scroll_en = 1'b1;
    evt_code = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_special_cases();
    test_extremes();
    test_config_registers();
    test_random_traffic();
    in_valid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
